### design/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ETP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ETP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/etp_pkg.sv
package etp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 112;
  localparam int SHIFT     = 2 * FRAC_BITS + 2;

  typedef enum logic [1:0] {
    FUNC_LOAD_TAN  = 2'd0,
    FUNC_LOAD_FINV = 2'd1,
    FUNC_LOAD_STR  = 2'd2,
    FUNC_COMPUTE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_CLR,
    MAC_P1,
    MAC_LO,
    MAC_HI
  } mac_op_t;

  localparam logic [3:0] TRIP [3][3] = '{'{4'd0, 4'd7, 4'd5},
                                         '{4'd3, 4'd1, 4'd8},
                                         '{4'd6, 4'd4, 4'd2}};

  localparam logic [1:0] RSEL1 [4][6] = '{
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] RSEL2 [4][6] = '{
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] FSEL1 [4][6] = '{
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}};
  localparam logic [1:0] FSEL2 [4][6] = '{
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0}};

  localparam logic [2:0] SSEL [24][6] = '{
    '{3'd0, 3'd3, 3'd5, 3'd3, 3'd5, 3'd0}, '{3'd3, 3'd1, 3'd4, 3'd1, 3'd4, 3'd3},
    '{3'd5, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5}, '{3'd3, 3'd1, 3'd4, 3'd1, 3'd4, 3'd3},
    '{3'd5, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd5, 3'd3, 3'd5, 3'd0},
    '{3'd0, 3'd3, 3'd5, 3'd0, 3'd3, 3'd5}, '{3'd3, 3'd1, 3'd4, 3'd3, 3'd1, 3'd4},
    '{3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2}, '{3'd3, 3'd1, 3'd4, 3'd3, 3'd1, 3'd4},
    '{3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2}, '{3'd0, 3'd3, 3'd5, 3'd0, 3'd3, 3'd5},
    '{3'd0, 3'd3, 3'd5, 3'd3, 3'd5, 3'd0}, '{3'd3, 3'd1, 3'd4, 3'd1, 3'd4, 3'd3},
    '{3'd5, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd5, 3'd3, 3'd5, 3'd0},
    '{3'd3, 3'd1, 3'd4, 3'd1, 3'd4, 3'd3}, '{3'd5, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5},
    '{3'd0, 3'd3, 3'd5, 3'd0, 3'd3, 3'd5}, '{3'd3, 3'd1, 3'd4, 3'd3, 3'd1, 3'd4},
    '{3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2}, '{3'd0, 3'd3, 3'd5, 3'd0, 3'd3, 3'd5},
    '{3'd3, 3'd1, 3'd4, 3'd3, 3'd1, 3'd4}, '{3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2}};

endpackage

### design/etp_ram.sv
module etp_ram #(
  parameter int DEPTH = 81,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### design/etp_mac.sv
module etp_mac
  import etp_pkg::*;
(
  input  logic                    clk,
  input  mac_op_t                 op,
  input  logic signed [32:0]      t,
  input  logic signed [31:0]      f,
  output logic signed [ACC_W-1:0] acc_r
);

  logic signed [64:0] p1_r;
  logic signed [32:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [65:0] prod;

  always_comb begin
    mul_y = 33'(f);
    case (op)
      MAC_P1:  mul_x = t;
      MAC_LO:  mul_x = $signed({1'b0, p1_r[31:0]});
      MAC_HI:  mul_x = $signed(p1_r[64:32]);
      default: mul_x = '0;
    endcase
  end

  assign prod = mul_x * mul_y;

  always_ff @(posedge clk) begin
    case (op)
      MAC_CLR: acc_r <= '0;
      MAC_P1:  p1_r <= prod[64:0];
      MAC_LO:  acc_r <= acc_r + ACC_W'(prod);
      MAC_HI:  acc_r <= acc_r + (ACC_W'(prod) <<< 32);
      default: acc_r <= acc_r;
    endcase
  end

endmodule

### design/elasticity_tangent_pullback.sv
// channel  | direction | contents
// in_      | input     | tuser: func; tdata: row, col, value
// out_     | output    | tdata: out_row, out_col, out_value; tlast: out_last
// a load is written into its store when accepted; a compute works out 36 entries in
// turn, each from 36 terms run through states A to E on the one shared multiplier,
// then a finish state and the output register; an output stall holds the sequencer
// rst_n is synchronous; the operand stores hold no reset value
module elasticity_tangent_pullback
  import etp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_row[2:0], out_col[5:3], out_value[69:6], zero
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_A, ST_B, ST_C, ST_D, ST_E, ST_FIN, ST_WAIT
  } state_t;

  state_t state_r;
  logic [2:0] i_r, j_r;
  logic [1:0] k_r, a_r, b_r;
  logic signed [32:0] t_r;
  logic signed [31:0] fa_r, fb_r;
  logic [2:0] orow_r, ocol_r;
  logic [63:0] oval_r;
  logic olast_r, ovalid_r;

  logic [3:0] in_row, in_col;
  logic [31:0] in_value;
  func_t in_func;
  logic in_acc;

  logic [6:0] tan_waddr, tan_raddr;
  logic [3:0] fi_waddr, fi_raddr;
  logic [2:0] st_raddr;
  logic [4:0] sidx;
  logic [31:0] tan_q, fi_q, st_q;
  logic tan_we, fi_we, st_we;

  mac_op_t mac_op;
  logic signed [31:0] mac_f;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic [63:0] sat_val;

  assign in_row   = in_tdata[3:0];
  assign in_col   = in_tdata[7:4];
  assign in_value = in_tdata[39:8];
  assign in_func  = func_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign tan_we = in_acc && in_func == FUNC_LOAD_TAN && in_row < 4'd9 && in_col < 4'd9;
  assign fi_we  = in_acc && in_func == FUNC_LOAD_FINV && in_row < 4'd3 && in_col < 4'd3;
  assign st_we  = in_acc && in_func == FUNC_LOAD_STR && in_row < 4'd6;
  assign tan_waddr = 7'({3'b0, in_row} * 7'd9 + {3'b0, in_col});
  assign fi_waddr  = 4'(in_row[1:0] * 4'd3 + {2'b0, in_col[1:0]});

  assign tan_raddr = 7'({3'b0, TRIP[RSEL1[k_r][i_r]][a_r]} * 7'd9
                        + {3'b0, TRIP[RSEL2[k_r][j_r]][b_r]});
  assign sidx      = 5'(i_r) + 5'(k_r) * 5'd6;
  assign st_raddr  = SSEL[sidx][j_r];
  assign fi_raddr  = (state_r == ST_B) ? 4'(FSEL2[k_r][j_r] * 4'd3 + {2'b0, b_r})
                                       : 4'(FSEL1[k_r][i_r] * 4'd3 + {2'b0, a_r});

  etp_ram #(.DEPTH(81), .WIDTH(32)) u_tan (
    .clk(clk), .we(tan_we), .waddr(tan_waddr), .wdata(in_value),
    .raddr(tan_raddr), .rdata_r(tan_q)
  );
  etp_ram #(.DEPTH(9), .WIDTH(32)) u_finv (
    .clk(clk), .we(fi_we), .waddr(fi_waddr), .wdata(in_value),
    .raddr(fi_raddr), .rdata_r(fi_q)
  );
  etp_ram #(.DEPTH(6), .WIDTH(32)) u_str (
    .clk(clk), .we(st_we), .waddr(in_row[2:0]), .wdata(in_value),
    .raddr(st_raddr), .rdata_r(st_q)
  );

  always_comb begin
    case (state_r)
      ST_IDLE: mac_op = (in_acc && in_func == FUNC_COMPUTE) ? MAC_CLR : MAC_IDLE;
      ST_C:    mac_op = MAC_P1;
      ST_D:    mac_op = MAC_LO;
      ST_E:    mac_op = MAC_HI;
      ST_FIN:  mac_op = MAC_CLR;
      default: mac_op = MAC_IDLE;
    endcase
  end

  assign mac_f = (state_r == ST_C) ? fa_r : fb_r;

  etp_mac u_mac (
    .clk(clk), .op(mac_op), .t(t_r), .f(mac_f), .acc_r(acc)
  );

  // scale by a quarter, round toward minus infinity, saturate
  assign shifted = acc >>> SHIFT;
  always_comb begin
    if (&shifted[ACC_W-1:63] || ~|shifted[ACC_W-1:63]) begin
      sat_val = shifted[63:0];
    end else if (acc[ACC_W-1]) begin
      sat_val = {1'b1, 63'b0};
    end else begin
      sat_val = {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      a_r <= '0;
      b_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_func == FUNC_COMPUTE) begin
            i_r <= '0;
            j_r <= '0;
            k_r <= '0;
            a_r <= '0;
            b_r <= '0;
            state_r <= ST_A;
          end
        end
        ST_A: state_r <= ST_B;
        ST_B: begin
          fa_r <= fi_q;
          t_r  <= 33'($signed(tan_q)) - ((a_r == b_r) ? 33'($signed(st_q)) : 33'sd0);
          state_r <= ST_C;
        end
        ST_C: begin
          fb_r <= fi_q;
          state_r <= ST_D;
        end
        ST_D: state_r <= ST_E;
        ST_E: begin
          state_r <= ST_A;
          if (b_r == 2'd2) begin
            b_r <= '0;
            if (a_r == 2'd2) begin
              a_r <= '0;
              k_r <= k_r + 2'd1;
              if (k_r == 2'd3) begin
                state_r <= ST_FIN;
              end
            end else begin
              a_r <= a_r + 2'd1;
            end
          end else begin
            b_r <= b_r + 2'd1;
          end
        end
        ST_FIN: begin
          orow_r   <= i_r;
          ocol_r   <= j_r;
          oval_r   <= sat_val;
          olast_r  <= (i_r == 3'd5) && (j_r == 3'd5);
          ovalid_r <= 1'b1;
          state_r  <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_tready) begin
            ovalid_r <= 1'b0;
            if (olast_r) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_A;
              if (j_r == 3'd5) begin
                j_r <= '0;
                i_r <= i_r + 3'd1;
              end else begin
                j_r <= j_r + 3'd1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, oval_r, ocol_r, orow_r};
  assign out_tlast  = olast_r;

endmodule

### design/etp_checker.sv
`include "assert_macros.svh"

module etp_checker
  import etp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  `ETP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ETP_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready)
  `ETP_ASSERT_NOW(a_index_range, out_tvalid, out_tdata[2:0] <= 3'd5 && out_tdata[5:3] <= 3'd5)
  `ETP_ASSERT_NEXT(a_last_done, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready)
  `ETP_ASSERT_NEXT(a_compute_busy, in_tvalid && in_tready && in_tuser == FUNC_COMPUTE, !in_tready)

endmodule

bind elasticity_tangent_pullback etp_checker u_etp_checker (.*);
